[design/ole_pkg.sv]
package ole_pkg;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_PREPEND = 3'd1,
		OP_DELETE  = 3'd2,
		OP_READ    = 3'd3,
		OP_LOOKUP  = 3'd4,
		OP_REMOVE  = 3'd5,
		OP_CLEAR   = 3'd6,
		OP_SHUFFLE = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_BADPOS    = 3'd2,
		ST_NOTFOUND  = 3'd3,
		ST_SHUF_DONE = 3'd4
	} status_t;

	localparam int KIND_W   = 3;
	localparam int IVAL_W   = 32;
	localparam int POS_W    = 6;
	localparam int RND_W    = 16;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IVAL_W-1:0] item_value;
		logic [POS_W-1:0]  position;
		logic [RND_W-1:0]  random_word;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IVAL_W-1:0]   found_value;
		logic [POS_W-1:0]    found_position;
		logic [LEN_W-1:0]    list_length;
	} rsp_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef enum logic [6:0] {
		CC_HOLD    = 7'b0000001,
		CC_SHUP    = 7'b0000010,
		CC_SHDN    = 7'b0000100,
		CC_LOAD    = 7'b0001000,
		CC_ROTL    = 7'b0010000,
		CC_SWAPA   = 7'b0100000,
		CC_SWAPB   = 7'b1000000
	} cell_op_t;

endpackage

[design/ole_if.sv]
interface ole_if #(
	parameter int W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/ole_cell.sv]
// One list slot. Every cell sees the same command; neighbors hand values up or down.
module ole_cell #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  ole_pkg::cell_op_t     op,
	input  logic                  sel,
	input  logic                  keep,
	input  logic [VALUE_BITS-1:0] from_low,
	input  logic [VALUE_BITS-1:0] from_high,
	input  logic [VALUE_BITS-1:0] load_val,
	output logic [VALUE_BITS-1:0] value
);
	logic [VALUE_BITS-1:0] value_q;

	assign value = value_q;

	always_ff @(posedge clk) begin
		if (sel) begin
			unique case (op)
				ole_pkg::CC_SHUP:  value_q <= from_low;
				ole_pkg::CC_SHDN:  value_q <= from_high;
				ole_pkg::CC_LOAD:  value_q <= load_val;
				ole_pkg::CC_ROTL:  value_q <= keep ? value_q : from_high;
				ole_pkg::CC_SWAPA: value_q <= load_val;
				ole_pkg::CC_SWAPB: value_q <= load_val;
				default:           value_q <= value_q;
			endcase
		end
	end
endmodule

[design/ole_ctrl.sv]
// Sequencer: walks the cell row one slot per cycle for searches and compaction,
// works out the modulo of a shuffle step bit-serially; shifts move the whole row at once.
module ole_ctrl #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ole_if.sink                           req,
	ole_if.source                         rsp,
	output ole_pkg::cell_op_t             cop,
	output logic [DEPTH-1:0]              csel,
	output logic [DEPTH-1:0]              ckeep,
	output logic [VALUE_BITS-1:0]         cload,
	input  logic [DEPTH-1:0][VALUE_BITS-1:0] cval
);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_MOD  = 6'b000100,
		S_SWP1 = 6'b001000,
		S_SWP2 = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                  state_q;
	ole_pkg::req_t           r_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           cur_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           kept_q;
	logic [16+CW-1:0]        rem_q;
	logic [4:0]              bit_q;
	logic [VALUE_BITS-1:0]   tmp_q;
	logic [ole_pkg::STATUS_W-1:0] st_q;
	logic [ole_pkg::POS_W-1:0]    fpos_q;
	logic [31:0]             fval_q;
	logic                    ovalid_q;
	ole_pkg::rsp_t           out_q;

	ole_pkg::req_t           rin;
	logic [VALUE_BITS-1:0]   val;
	logic [CW-1:0]           remaining;
	logic [16+CW-1:0]        rem_sh;
	logic [CW-1:0]           partner;
	logic [VALUE_BITS-1:0]   cur_ent;
	logic [IW-1:0]           idx_i;

	assign rin     = req.data;
	assign val     = VALUE_BITS'(r_q.item_value);
	assign remaining = cnt_q - cur_q;
	assign rem_sh  = {rem_q[16+CW-2:0], 1'b0};
	assign partner = cur_q + rem_q[CW-1:0];
	assign idx_i   = idx_q[IW-1:0];
	assign cur_ent = cval[idx_i];
	assign req.ready = (state_q == S_IDLE) && !ovalid_q;
	assign rsp.valid = ovalid_q;
	assign rsp.data  = out_q;

	always_comb begin
		cop   = ole_pkg::CC_HOLD;
		csel  = '0;
		ckeep = '0;
		cload = val;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready) begin
					cload = VALUE_BITS'(rin.item_value);
					if (rin.kind == ole_pkg::OP_APPEND && CW'(cnt_q) < CW'(DEPTH)) begin
						cop = ole_pkg::CC_LOAD;
						csel[cnt_q[IW-1:0]] = 1'b1;
					end else if (rin.kind == ole_pkg::OP_PREPEND
						&& CW'(cnt_q) < CW'(DEPTH)) begin
						cop = ole_pkg::CC_SHUP;
						csel = '1;
					end else if (rin.kind == ole_pkg::OP_DELETE
						&& CW'(rin.position) < cnt_q) begin
						cop = ole_pkg::CC_SHDN;
						for (int i = 0; i < DEPTH; i++)
							csel[i] = CW'(i) >= CW'(rin.position);
					end
				end
			end
			S_SCAN: begin
				if (r_q.kind == ole_pkg::OP_REMOVE && idx_q < cnt_q) begin
					// move the survivor at idx down to the kept slot
					cop = ole_pkg::CC_LOAD;
					cload = cur_ent;
					csel[kept_q[IW-1:0]] = (cur_ent != val);
				end
			end
			S_SWP1: begin
				cop = ole_pkg::CC_SWAPA;
				cload = cval[partner[IW-1:0]];
				csel[cur_q[IW-1:0]] = 1'b1;
			end
			S_SWP2: begin
				cop = ole_pkg::CC_SWAPB;
				cload = tmp_q;
				csel[partner[IW-1:0]] = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			cur_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						r_q    <= rin;
						st_q   <= ole_pkg::ST_OK;
						fpos_q <= '0;
						fval_q <= '0;
						idx_q  <= '0;
						kept_q <= '0;
						state_q <= S_DONE;
						unique case (ole_pkg::op_t'(rin.kind))
							ole_pkg::OP_APPEND, ole_pkg::OP_PREPEND: begin
								if (cnt_q < CW'(DEPTH))
									cnt_q <= cnt_q + 1'b1;
								else
									st_q <= ole_pkg::ST_FULL;
							end
							ole_pkg::OP_DELETE: begin
								if (CW'(rin.position) < cnt_q)
									cnt_q <= cnt_q - 1'b1;
								else
									st_q <= ole_pkg::ST_BADPOS;
							end
							ole_pkg::OP_READ: begin
								if (CW'(rin.position) < cnt_q)
									fval_q <= 32'(cval[rin.position[IW-1:0]]);
								else
									st_q <= ole_pkg::ST_BADPOS;
							end
							ole_pkg::OP_LOOKUP, ole_pkg::OP_REMOVE: begin
								st_q    <= ole_pkg::ST_NOTFOUND;
								state_q <= S_SCAN;
							end
							ole_pkg::OP_CLEAR: begin
								cnt_q <= '0;
								cur_q <= '0;
							end
							default: begin
								if (cur_q + 1'b1 >= cnt_q) begin
									st_q  <= ole_pkg::ST_SHUF_DONE;
									cur_q <= '0;
								end else begin
									rem_q   <= '0;
									bit_q   <= 5'd15;
									state_q <= S_MOD;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (idx_q >= cnt_q) begin
						if (r_q.kind == ole_pkg::OP_REMOVE) begin
							cnt_q <= kept_q;
							st_q  <= (kept_q == cnt_q) ? ole_pkg::ST_NOTFOUND
								: ole_pkg::ST_OK;
						end
						state_q <= S_DONE;
					end else if (r_q.kind == ole_pkg::OP_LOOKUP) begin
						if (cur_ent == val) begin
							st_q   <= ole_pkg::ST_OK;
							fpos_q <= ole_pkg::POS_W'(idx_q);
							state_q <= S_DONE;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						if (cur_ent != val)
							kept_q <= kept_q + 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				S_MOD: begin
					// one restoring step of random_word mod remaining
					if ((rem_sh | (16+CW)'(r_q.random_word[bit_q[3:0]]))
						>= (16+CW)'(remaining))
						rem_q <= (rem_sh | (16+CW)'(r_q.random_word[bit_q[3:0]]))
							- (16+CW)'(remaining);
					else
						rem_q <= rem_sh | (16+CW)'(r_q.random_word[bit_q[3:0]]);
					if (bit_q == 5'd0)
						state_q <= S_SWP1;
					bit_q <= bit_q - 1'b1;
				end
				S_SWP1: begin
					tmp_q   <= cval[cur_q[IW-1:0]];
					state_q <= S_SWP2;
				end
				S_SWP2: begin
					cur_q   <= cur_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ovalid_q || rsp.ready) begin
						out_q.status         <= st_q;
						out_q.found_value    <= fval_q;
						out_q.found_position <= fpos_q;
						out_q.list_length    <= ole_pkg::LEN_W'(cnt_q);
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[design/ordered_list_engine_top.sv]
// Ordered list engine: a row of DEPTH value cells driven by a sequencer.
// Channels: in (kind, item_value, position, random_word) and out (status,
// found_value, found_position, list_length), valid/ready; every request
// yields exactly one result.
// Work after a request is accepted, until the result is registered:
//   append, prepend, delete, read, clear: done at acceptance (prepend and delete shift cells in parallel)
//   lookup: scan to a match or the list end; remove value: scan the whole list
//   shuffle step: 16 bit-serial modulo steps, then a swap in states S_SWP1 and S_SWP2
// One request is in flight at a time; the next is taken once the result
// register is empty. Reset clears the count, shuffle cursor and result valid;
// cell contents are undefined until written. A stalled receiver holds the
// result register and the engine takes no new request until it drains.
module ordered_list_engine_top #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	ole_if.sink  in_req,
	ole_if.source out_rsp
);
	ole_pkg::cell_op_t                 cop;
	logic [DEPTH-1:0]                  csel;
	logic [DEPTH-1:0]                  ckeep;
	logic [VALUE_BITS-1:0]             cload;
	logic [DEPTH-1:0][VALUE_BITS-1:0]  cval;

	ole_ctrl #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .req(in_req), .rsp(out_rsp),
		.cop(cop), .csel(csel), .ckeep(ckeep), .cload(cload), .cval(cval)
	);

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		ole_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
			.clk(clk), .op(cop), .sel(csel[g]), .keep(ckeep[g]),
			.from_low((g == 0) ? cload : cval[(g == 0) ? 0 : g-1]),
			.from_high(cval[(g == DEPTH-1) ? g : g+1]),
			.load_val(cload), .value(cval[g])
		);
	end
endmodule

[design/ole_checker.sv]
module ole_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed under stall");
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");
	a_no_in_with_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while result pending");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data[6:0] <= 7'd64)
		else $error("length out of range");
endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_req.valid), .in_ready(in_req.ready),
	.out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
	.out_data(out_rsp.data)
);

[test/ole_list_checker.sv]
`timescale 1ns / 100ps

module ole_list_checker
	import ole_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_data,
	output int   errors,
	output int   pending
);

	localparam int DEPTH = 64;

	logic [IVAL_W-1:0] list_row [DEPTH];
	int                list_count;
	int                shuffle_at;
	rsp_t              awaited_rsp [$];

	function automatic rsp_t apply_request(req_t r);
		rsp_t              res;
		int                kept;
		int                partner;
		int                remaining;
		logic [IVAL_W-1:0] held;
		res = '0;
		res.status = ST_OK;
		case (op_t'(r.kind))
			OP_APPEND: begin
				if (list_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					list_row[list_count] = r.item_value;
					list_count++;
				end
			end
			OP_PREPEND: begin
				if (list_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (int i = list_count; i > 0; i--)
						list_row[i] = list_row[i-1];
					list_row[0] = r.item_value;
					list_count++;
				end
			end
			OP_DELETE: begin
				if (r.position >= list_count) begin
					res.status = ST_BADPOS;
				end else begin
					for (int i = r.position; i + 1 < list_count; i++)
						list_row[i] = list_row[i+1];
					list_count--;
				end
			end
			OP_READ: begin
				if (r.position >= list_count)
					res.status = ST_BADPOS;
				else
					res.found_value = list_row[r.position];
			end
			OP_LOOKUP: begin
				res.status = ST_NOTFOUND;
				for (int i = 0; i < list_count; i++) begin
					if (list_row[i] == r.item_value) begin
						res.status = ST_OK;
						res.found_position = POS_W'(i);
						break;
					end
				end
			end
			OP_REMOVE: begin
				kept = 0;
				for (int i = 0; i < list_count; i++) begin
					if (list_row[i] != r.item_value) begin
						list_row[kept] = list_row[i];
						kept++;
					end
				end
				if (kept == list_count)
					res.status = ST_NOTFOUND;
				list_count = kept;
			end
			OP_CLEAR: begin
				list_count = 0;
				shuffle_at = 0;
			end
			default: begin
				if (shuffle_at + 1 >= list_count) begin
					res.status = ST_SHUF_DONE;
					shuffle_at = 0;
				end else begin
					remaining = list_count - shuffle_at;
					partner = shuffle_at + (int'(r.random_word) % remaining);
					held = list_row[shuffle_at];
					list_row[shuffle_at] = list_row[partner];
					list_row[partner] = held;
					shuffle_at++;
				end
			end
		endcase
		res.list_length = LEN_W'(list_count);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			list_count = 0;
			shuffle_at = 0;
			errors = 0;
			awaited_rsp.delete();
			pending = 0;
		end else begin
			if (req_valid && req_ready)
				awaited_rsp.push_back(apply_request(req_data));
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					errors++;
					$display("%0t: result with none awaited: %p", $time, rsp_data);
				end else begin
					want = awaited_rsp.pop_front();
					if (want.status !== rsp_data.status) begin
						errors++;
						$display("%0t: status expected %0d got %0d",
							$time, want.status, rsp_data.status);
					end
					if (want.found_value !== rsp_data.found_value) begin
						errors++;
						$display("%0t: found_value expected %h got %h",
							$time, want.found_value, rsp_data.found_value);
					end
					if (want.found_position !== rsp_data.found_position) begin
						errors++;
						$display("%0t: found_position expected %0d got %0d",
							$time, want.found_position, rsp_data.found_position);
					end
					if (want.list_length !== rsp_data.list_length) begin
						errors++;
						$display("%0t: list_length expected %0d got %0d",
							$time, want.list_length, rsp_data.list_length);
					end
				end
			end
			pending = awaited_rsp.size();
		end
	end

endmodule

[test/tb_ordered_list_engine_top.sv]
`timescale 1ns / 100ps

module tb_ordered_list_engine_top;
	import ole_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_pct;
	int   stall_pct;
	logic long_hold;
	logic hold_done;
	int   quiet_cycles;
	logic [IVAL_W-1:0] value_pool [8];

	ole_if #(.W($bits(req_t))) req_ch ();
	ole_if #(.W($bits(rsp_t))) rsp_ch ();

	ordered_list_engine_top #(.DEPTH(64), .VALUE_BITS(32)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_req  (req_ch),
		.out_rsp (rsp_ch)
	);

	ole_list_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.req_data  (req_t'(req_ch.data)),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.rsp_data  (rsp_t'(rsp_ch.data)),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_ordered_list_engine_top: errors");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off to back up the engine.
	initial begin
		rsp_ch.ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				rsp_ch.ready <= (arst_n && $urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_request(input op_t op, input logic [IVAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input logic [RND_W-1:0] rnd);
		req_t r;
		r.kind = op;
		r.item_value = val;
		r.position = pos;
		r.random_word = rnd;
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	function automatic logic [IVAL_W-1:0] pick_value();
		if ($urandom_range(1))
			return value_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(1))
			return POS_W'($urandom_range(63));
		return POS_W'($urandom_range(7));
	endfunction

	task automatic random_phase(input int n_items);
		int sent;
		int roll;
		int burst;
		logic fill_mode;
		op_t op;
		sent = 0;
		fill_mode = 1'b0;
		while (sent < n_items) begin
			if (sent % 120 == 0)
				fill_mode = $urandom_range(2) == 0;
			roll = $urandom_range(99);
			if (fill_mode && roll < 45)
				op = OP_APPEND;
			else if (fill_mode && roll < 80)
				op = OP_PREPEND;
			else if (roll < 3)
				op = OP_CLEAR;
			else
				case ($urandom_range(6))
					0: op = OP_APPEND;
					1: op = OP_PREPEND;
					2: op = OP_DELETE;
					3: op = OP_READ;
					4: op = OP_LOOKUP;
					5: op = OP_REMOVE;
					default: op = OP_SHUFFLE;
				endcase
			// Run shuffle steps as a sequence so the cursor walks far.
			burst = (op == OP_SHUFFLE) ? $urandom_range(1, 40) : 1;
			repeat (burst) begin
				send_request(op, pick_value(), pick_position(),
					RND_W'($urandom_range(16'hffff)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		idle_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		value_pool = '{32'h0, 32'hffff_ffff, 32'h1, 32'h8000_0000,
			32'h5555_aaaa, 32'haaaa_5555, 32'h7, 32'h1234_5678};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty list cases, extremes, every operation.
		send_request(OP_READ, 32'h0, 6'd0, 16'h0);
		send_request(OP_DELETE, 32'h0, 6'd63, 16'h0);
		send_request(OP_SHUFFLE, 32'h0, 6'd0, 16'hffff);
		send_request(OP_LOOKUP, 32'h0, 6'd0, 16'h0);
		send_request(OP_REMOVE, 32'h0, 6'd0, 16'h0);
		send_request(OP_APPEND, 32'h0, 6'd0, 16'h0);
		send_request(OP_APPEND, 32'hffff_ffff, 6'd63, 16'hffff);
		send_request(OP_PREPEND, 32'h8000_0001, 6'd0, 16'h0);
		send_request(OP_APPEND, 32'hffff_ffff, 6'd0, 16'h0);
		send_request(OP_READ, 32'h0, 6'd2, 16'h0);
		send_request(OP_READ, 32'h0, 6'd4, 16'h0);
		send_request(OP_LOOKUP, 32'hffff_ffff, 6'd0, 16'h0);
		send_request(OP_LOOKUP, 32'h1234_5678, 6'd0, 16'h0);
		send_request(OP_SHUFFLE, 32'h0, 6'd0, 16'hffff);
		send_request(OP_SHUFFLE, 32'h0, 6'd0, 16'h0001);
		send_request(OP_SHUFFLE, 32'h0, 6'd0, 16'h0);
		send_request(OP_SHUFFLE, 32'h0, 6'd0, 16'h8000);
		send_request(OP_REMOVE, 32'hffff_ffff, 6'd0, 16'h0);
		send_request(OP_REMOVE, 32'h1234_5678, 6'd0, 16'h0);
		send_request(OP_DELETE, 32'h0, 6'd0, 16'h0);
		send_request(OP_DELETE, 32'h0, 6'd1, 16'h0);
		send_request(OP_CLEAR, 32'h0, 6'd0, 16'h0);
		send_request(OP_READ, 32'h0, 6'd0, 16'h0);

		long_hold = 1'b1;
		random_phase(270);
		idle_pct = 59;
		random_phase(270);
		idle_pct = 0;
		stall_pct = 59;
		random_phase(270);
		idle_pct = 15;
		stall_pct = 15;
		random_phase(270);
		req_ch.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		if (errors == 0)
			$display("tb_ordered_list_engine_top: clean");
		else
			$display("tb_ordered_list_engine_top: errors");
		$finish;
	end

endmodule
